/* hdl/pbfl_pkg.sv */
`default_nettype none
package pbfl_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ACC_W    = 64;
    localparam int CNT_W    = 4;
    localparam int PHASE_W  = 3;
    localparam int OUTC_W   = 2;

    localparam logic [CNT_W-1:0] VARINT_MAX_BYTES = 4'd10;

    localparam logic [PHASE_W-1:0] PH_TAG   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_VALUE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

    localparam logic [OUTC_W-1:0] OUT_UNDECIDED = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_FAILED    = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_CANDIDATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERRUN   = 2'd2;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LENGTH = 3'd2;
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    localparam logic [60:0] PAYLOAD_FIELD_ID = 61'h0f;

    localparam logic [ACC_W-1:0] SKIP_FIX64 = 64'd8;
    localparam logic [ACC_W-1:0] SKIP_FIX32 = 64'd4;

endpackage
`default_nettype wire

/* hdl/protobuf_payload_field_locator.sv */
// An accepted byte marked last yields its status on o_valid from the output register in the next cycle.
// Throughput: one byte per cycle while o_stall is low; bytes not marked last produce nothing.
// o_stall rises only while a status waits in the output register and i_stall is high.
// Reset (synchronous, active low) returns the scanner to tag parsing at offset 0.
// After each last byte the scanner restarts on its own for the next fragment.
`default_nettype none
module protobuf_payload_field_locator #(
    parameter int OFFSET_BITS = pbfl_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pbfl_pkg::DATA_W-1:0]   i_data_byte,
    input  wire logic                          i_last_byte,
    input  wire logic [pbfl_pkg::LEN_W-1:0]    i_message_length,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pbfl_pkg::STATUS_W-1:0]      o_status,
    output logic [pbfl_pkg::LEN_W-1:0]         o_metadata_length,
    output logic [pbfl_pkg::LEN_W-1:0]         o_payload_offset
);
    import pbfl_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam logic [OB-1:0] MAX_OFF = {OB{1'b1}};

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_is_payload, n_is_payload;
    logic [OB-1:0]      r_pos, n_pos;
    logic [OB-1:0]      r_fstart, n_fstart;
    logic [ACC_W-1:0]   r_skip, n_skip;
    logic [OB-1:0]      r_cand_tag, n_cand_tag;
    logic [OB-1:0]      r_cand_pay, n_cand_pay;
    logic [OB:0]        r_cand_end, n_cand_end;
    logic [OUTC_W-1:0]  r_outc, n_outc;
    logic [LEN_W-1:0]   r_held, n_held;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [LEN_W-1:0]    r_meta, n_meta;
    logic [LEN_W-1:0]    r_poff, n_poff;

    logic               in_acc;
    logic               out_acc;
    logic [ACC_W-1:0]   acc_sum;
    logic [ACC_W-1:0]   shifted;
    logic [CNT_W-1:0]   cnt_inc;
    logic [OB-1:0]      start;
    logic [OB+1:0]      end_sum;
    logic [ACC_W-1:0]   meta_ext;
    logic [ACC_W-1:0]   poff_ext;

    assign o_stall = r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = r_out_valid & ~i_stall;

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_metadata_length = r_meta;
    assign o_payload_offset  = r_poff;

    assign shifted = {57'd0, i_data_byte[6:0]} << (7'(r_cnt) * 7'd7);
    assign acc_sum = (r_cnt < VARINT_MAX_BYTES) ? (r_acc | shifted) : r_acc;
    assign cnt_inc = r_cnt + 4'd1;
    assign start   = (r_pos == MAX_OFF) ? r_pos : r_pos + 1'b1;
    assign end_sum = (OB+2)'(start) + (OB+2)'(acc_sum[OB:0]);

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_is_payload = r_is_payload;
        n_fstart     = r_fstart;
        n_skip       = r_skip;
        n_cand_tag   = r_cand_tag;
        n_cand_pay   = r_cand_pay;
        n_cand_end   = r_cand_end;
        n_outc       = r_outc;
        n_held       = r_held;
        n_pos        = (r_pos == MAX_OFF) ? r_pos : r_pos + 1'b1;

        if (r_pos == '0) begin
            n_held = i_message_length;
        end

        unique case (r_phase)
            PH_TAG, PH_VALUE, PH_LEN: begin
                if (r_phase == PH_TAG && r_cnt == '0) begin
                    n_fstart = r_pos;
                end
                if (i_data_byte[7]) begin
                    n_acc = acc_sum;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= VARINT_MAX_BYTES) begin
                        n_outc  = OUT_FAILED;
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_acc = '0;
                    n_cnt = '0;
                    if (r_phase == PH_TAG) begin
                        n_is_payload = (acc_sum[63:3] == PAYLOAD_FIELD_ID);
                        unique case (acc_sum[2:0])
                            WT_VARINT: n_phase = PH_VALUE;
                            WT_LENGTH: n_phase = PH_LEN;
                            WT_FIX64: begin
                                n_phase = PH_SKIP;
                                n_skip  = SKIP_FIX64;
                            end
                            WT_FIX32: begin
                                n_phase = PH_SKIP;
                                n_skip  = SKIP_FIX32;
                            end
                            WT_SGROUP, WT_EGROUP: n_phase = PH_TAG;
                            default: begin
                                n_outc  = OUT_FAILED;
                                n_phase = PH_DONE;
                            end
                        endcase
                    end else if (r_phase == PH_VALUE) begin
                        n_phase = PH_TAG;
                    end else if (r_is_payload) begin
                        n_cand_tag = r_fstart;
                        n_cand_pay = start;
                        if ((|acc_sum[ACC_W-1:OB+1]) || end_sum[OB+1]) begin
                            n_cand_end = {(OB+1){1'b1}};
                        end else begin
                            n_cand_end = end_sum[OB:0];
                        end
                        n_outc  = OUT_CANDIDATE;
                        n_phase = PH_DONE;
                    end else if (acc_sum == '0) begin
                        n_phase = PH_TAG;
                    end else begin
                        n_skip  = acc_sum;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (r_skip != '0) begin
                    n_skip = r_skip - 1'b1;
                end
                if (n_skip == '0) begin
                    n_phase = PH_TAG;
                end
            end
            default: ;
        endcase

        n_status = ST_NOT_FOUND;
        meta_ext = 64'(n_held);
        poff_ext = '0;
        if (n_outc == OUT_CANDIDATE) begin
            if (n_cand_end >= (OB+1)'(r_pos)) begin
                n_status = ST_FOUND;
                meta_ext = 64'(n_cand_tag);
                poff_ext = 64'(n_cand_pay);
            end
        end else if (n_outc == OUT_UNDECIDED) begin
            if (n_phase == PH_SKIP && n_skip != '0) begin
                n_status = ST_OVERRUN;
            end
        end
        n_meta = meta_ext[LEN_W-1:0];
        n_poff = poff_ext[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TAG;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_is_payload <= 1'b0;
            r_pos        <= '0;
            r_fstart     <= '0;
            r_skip       <= '0;
            r_cand_tag   <= '0;
            r_cand_pay   <= '0;
            r_cand_end   <= '0;
            r_outc       <= OUT_UNDECIDED;
            r_held       <= '0;
        end else if (in_acc) begin
            if (i_last_byte) begin
                r_phase      <= PH_TAG;
                r_acc        <= '0;
                r_cnt        <= '0;
                r_is_payload <= 1'b0;
                r_pos        <= '0;
                r_fstart     <= '0;
                r_skip       <= '0;
                r_cand_tag   <= '0;
                r_cand_pay   <= '0;
                r_cand_end   <= '0;
                r_outc       <= OUT_UNDECIDED;
                r_held       <= '0;
            end else begin
                r_phase      <= n_phase;
                r_acc        <= n_acc;
                r_cnt        <= n_cnt;
                r_is_payload <= n_is_payload;
                r_pos        <= n_pos;
                r_fstart     <= n_fstart;
                r_skip       <= n_skip;
                r_cand_tag   <= n_cand_tag;
                r_cand_pay   <= n_cand_pay;
                r_cand_end   <= n_cand_end;
                r_outc       <= n_outc;
                r_held       <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_status <= n_status;
            r_meta   <= n_meta;
            r_poff   <= n_poff;
        end
    end

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte |=> r_pos == '0 && r_phase == PH_TAG && r_outc == OUT_UNDECIDED)
        else $error("scanner not restarted after last byte");

    a_done_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |-> r_outc != OUT_UNDECIDED)
        else $error("scan finished without an outcome");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_skip != '0)
        else $error("skip phase with nothing to skip");

    a_varint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_DONE |-> r_cnt < VARINT_MAX_BYTES)
        else $error("varint byte count overran");

    a_found_has_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte && n_status == ST_FOUND |-> n_outc == OUT_CANDIDATE)
        else $error("found status without a candidate");

endmodule
`default_nettype wire

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbfl_pkg::*;

    localparam logic [2:0] WT_BAD6 = 3'd6;
    localparam logic [2:0] WT_BAD7 = 3'd7;

    localparam int N_RANDOM    = 1950;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_LEN    = 300;
    localparam int QUIET_FROM  = 1000;
    localparam int QUIET_TO    = 1600;
    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic [7:0]  data;
        logic        lst;
        logic [31:0] mlen;
        logic        hold;
    } t_req;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] meta;
        logic [31:0] poff;
    } t_locate_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic [31:0] i_message_length;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [31:0] o_metadata_length;
    logic [31:0] o_payload_offset;

    t_req        fragment_reqs[$];
    t_locate_res pending_status[$];
    logic [7:0]  frag[$];

    int   cyc = 0;
    int   stuck = 0;
    int   req_count = 0;
    int   err_count = 0;
    int   frag_count = 0;
    int   hold_left = 0;
    logic req_taken = 1'b0;
    logic timed_out = 1'b0;

    // scanner state
    logic [2:0]  sc_phase;
    logic [63:0] sc_acc;
    int          sc_nbytes;
    logic        sc_payload_tag;
    logic [31:0] sc_pos;
    logic [31:0] sc_field_start;
    logic [63:0] sc_skip;
    logic [1:0]  sc_outcome;
    logic [31:0] sc_cand_tag;
    logic [31:0] sc_cand_start;
    logic [32:0] sc_cand_end;
    logic [31:0] sc_msg_len;

    protobuf_payload_field_locator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_message_length (i_message_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_metadata_length(o_metadata_length),
        .o_payload_offset (o_payload_offset)
    );

    always #5ns i_clk = ~i_clk;

    function automatic void scan_clear();
        sc_phase       = PH_TAG;
        sc_acc         = '0;
        sc_nbytes      = 0;
        sc_payload_tag = 1'b0;
        sc_pos         = '0;
        sc_field_start = '0;
        sc_skip        = '0;
        sc_outcome     = OUT_UNDECIDED;
        sc_cand_tag    = '0;
        sc_cand_start  = '0;
        sc_cand_end    = '0;
        sc_msg_len     = '0;
    endfunction

    function automatic void scan_fail();
        sc_outcome = OUT_FAILED;
        sc_phase   = PH_DONE;
    endfunction

    function automatic void locate_byte(input logic [7:0] b, input logic lst,
                                        input logic [31:0] mlen);
        logic [31:0] pos;
        logic [63:0] v;
        logic [2:0]  ph;
        logic [31:0] start;
        t_locate_res r;
        pos = sc_pos;
        if (pos == 0)
            sc_msg_len = mlen;
        if (sc_phase == PH_TAG || sc_phase == PH_VALUE || sc_phase == PH_LEN) begin
            if (sc_phase == PH_TAG && sc_nbytes == 0)
                sc_field_start = pos;
            if (sc_nbytes < 10)
                sc_acc = sc_acc | ({57'd0, b[6:0]} << (7 * sc_nbytes));
            sc_nbytes++;
            if (b[7]) begin
                if (sc_nbytes >= 10)
                    scan_fail();
            end else begin
                v = sc_acc;
                ph = sc_phase;
                sc_acc = '0;
                sc_nbytes = 0;
                if (ph == PH_TAG) begin
                    sc_payload_tag = (v[63:3] == PAYLOAD_FIELD_ID);
                    case (v[2:0])
                        WT_VARINT: sc_phase = PH_VALUE;
                        WT_LENGTH: sc_phase = PH_LEN;
                        WT_FIX64: begin
                            sc_phase = PH_SKIP;
                            sc_skip  = SKIP_FIX64;
                        end
                        WT_FIX32: begin
                            sc_phase = PH_SKIP;
                            sc_skip  = SKIP_FIX32;
                        end
                        WT_SGROUP, WT_EGROUP: sc_phase = PH_TAG;
                        default: scan_fail();
                    endcase
                end else if (ph == PH_VALUE) begin
                    sc_phase = PH_TAG;
                end else if (sc_payload_tag) begin
                    start = (pos == '1) ? pos : pos + 32'd1;
                    sc_cand_tag   = sc_field_start;
                    sc_cand_start = start;
                    if (v > 64'h1_FFFF_FFFF - 64'(start))
                        sc_cand_end = '1;
                    else
                        sc_cand_end = 33'(start) + v[32:0];
                    sc_outcome = OUT_CANDIDATE;
                    sc_phase   = PH_DONE;
                end else if (v == 0) begin
                    sc_phase = PH_TAG;
                end else begin
                    sc_skip  = v;
                    sc_phase = PH_SKIP;
                end
            end
        end else if (sc_phase == PH_SKIP) begin
            if (sc_skip != 0)
                sc_skip = sc_skip - 64'd1;
            if (sc_skip == 0)
                sc_phase = PH_TAG;
        end
        sc_pos = (pos == '1) ? pos : pos + 32'd1;
        if (lst) begin
            r.st   = ST_NOT_FOUND;
            r.meta = sc_msg_len;
            r.poff = '0;
            if (sc_outcome == OUT_CANDIDATE) begin
                if (sc_cand_end >= {1'b0, pos}) begin
                    r.st   = ST_FOUND;
                    r.meta = sc_cand_tag;
                    r.poff = sc_cand_start;
                end
            end else if (sc_outcome == OUT_UNDECIDED && sc_phase == PH_SKIP && sc_skip != 0) begin
                r.st = ST_OVERRUN;
            end
            pending_status.insert(pending_status.size(), r);
            scan_clear();
        end
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] tag_byte(input logic [3:0] id, input logic [2:0] wt);
        return {1'b0, id, wt};
    endfunction

    function automatic int pad_len();
        return ($urandom_range(7) == 0) ? int'($urandom_range(1, 4)) : 0;
    endfunction

    function automatic logic [63:0] any_value();
        case ($urandom_range(3))
            0: return 64'($urandom_range(0, 127));
            1: return {$urandom, $urandom} >> $urandom_range(63);
            2: return '1;
            default: return 64'($urandom_range(128, 20000));
        endcase
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        frag.insert(frag.size(), b);
    endfunction

    // pad > 0 gives a non-minimal encoding, capped at ten bytes
    function automatic void put_varint(input logic [63:0] v, input int pad);
        logic [63:0] r;
        int nb;
        int p;
        r = v;
        nb = 1;
        while (r > 64'h7f) begin
            put_byte({1'b1, r[6:0]});
            r = r >> 7;
            nb++;
        end
        p = (pad > 10 - nb) ? 10 - nb : pad;
        if (p > 0) begin
            put_byte({1'b1, r[6:0]});
            repeat (p - 1) put_byte(8'h80);
            put_byte(8'h00);
        end else begin
            put_byte({1'b0, r[6:0]});
        end
    endfunction

    function automatic void put_field();
        logic [60:0] id;
        logic [2:0]  wt;
        int          sl;
        case ($urandom_range(9))
            0: id = 61'({$urandom, $urandom} >> 3);
            1: id = 61'd15 | (61'd1 << $urandom_range(4, 60));
            default: id = 61'($urandom_range(1, 40));
        endcase
        case ($urandom_range(5))
            0: wt = WT_VARINT;
            1: wt = WT_FIX64;
            2: wt = WT_FIX32;
            3, 4: wt = WT_LENGTH;
            default: wt = $urandom_range(1) ? WT_SGROUP : WT_EGROUP;
        endcase
        if (wt == WT_LENGTH && id == 61'd15)
            id = 61'd16;
        put_varint({id, wt}, pad_len());
        case (wt)
            WT_VARINT: begin
                if ($urandom_range(9) == 0) begin
                    repeat (9) put_byte(rnd_byte() | 8'h80);
                    put_byte(rnd_byte() & 8'h7f);
                end else begin
                    put_varint(any_value(), pad_len());
                end
            end
            WT_FIX64: repeat (8) put_byte(rnd_byte());
            WT_FIX32: repeat (4) put_byte(rnd_byte());
            WT_LENGTH: begin
                sl = $urandom_range(0, 6);
                put_varint(64'(sl), pad_len());
                repeat (sl) put_byte(rnd_byte());
            end
            default: ;
        endcase
    endfunction

    function automatic void push_frag(input logic [31:0] ml, input logic hold);
        t_req r;
        for (int i = 0; i < frag.size(); i++) begin
            r.data = frag[i];
            r.lst  = (i == frag.size() - 1);
            r.mlen = (i == 0) ? ml : $urandom;
            r.hold = hold && (i == 0);
            fragment_reqs.insert(fragment_reqs.size(), r);
        end
    endfunction

    function automatic void add_fragment();
        int          kind;
        int          sl;
        int          m;
        int          cut;
        logic [63:0] clen;
        logic [2:0]  wt;
        logic [31:0] ml;
        kind = $urandom_range(99);
        frag.delete();
        repeat ($urandom_range(0, 4)) put_field();
        if (kind < 55) begin
            put_varint({PAYLOAD_FIELD_ID, WT_LENGTH}, pad_len());
            case ($urandom_range(7))
                0: begin
                    clen = any_value();
                    m = $urandom_range(0, 3);
                end
                1: begin
                    clen = 64'h1_FFFF_FFFF - 64'($urandom_range(0, 40));
                    m = $urandom_range(0, 3);
                end
                default: begin
                    sl = $urandom_range(0, 6);
                    clen = 64'(sl);
                    m = $urandom_range(sl < 2 ? 0 : sl - 2, sl + 2);
                end
            endcase
            put_varint(clen, pad_len());
            repeat (m) put_byte(rnd_byte());
        end else if (kind < 65) begin
            wt = $urandom_range(1) ? WT_BAD6 : WT_BAD7;
            put_varint({61'($urandom_range(1, 40)), wt}, 0);
            repeat ($urandom_range(0, 4)) put_byte(rnd_byte());
        end else if (kind < 72) begin
            repeat (10) put_byte(rnd_byte() | 8'h80);
            repeat ($urandom_range(0, 3)) put_byte(rnd_byte());
        end else if (kind < 82) begin
            repeat ($urandom_range(1, 16)) put_byte(rnd_byte());
        end else if (kind < 90) begin
            put_varint({61'($urandom_range(1, 14)), WT_LENGTH}, pad_len());
            put_varint(any_value() | 64'd8, pad_len());
            repeat ($urandom_range(0, 6)) put_byte(rnd_byte());
        end else begin
            put_field();
        end
        if ($urandom_range(4) == 0 && frag.size() > 1) begin
            cut = $urandom_range(1, frag.size());
            while (frag.size() > cut) frag.delete(frag.size() - 1);
        end
        if (frag.size() == 0)
            put_byte(rnd_byte());
        case ($urandom_range(5))
            0: ml = '0;
            1: ml = '1;
            default: ml = $urandom;
        endcase
        push_frag(ml, frag_count % 25 == 0);
        frag_count++;
    endfunction

    function automatic logic gap_now();
        return (cyc < QUIET_FROM || cyc >= QUIET_TO) && ($urandom_range(99) < 12);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_req nxt;
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (fragment_reqs.size() != 0 &&
                !(fragment_reqs[0].hold && pending_status.size() != 0) && !gap_now()) begin
                nxt = fragment_reqs.pop_front();
                i_valid          <= 1'b1;
                i_data_byte      <= nxt.data;
                i_last_byte      <= nxt.lst;
                i_message_length <= nxt.mlen;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result back-pressure, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (cyc == HOLD_AT) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_LEN;
        end else begin
            i_stall <= gap_now();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_locate_res want;
        if (i_rst_n) begin
            cyc       <= cyc + 1;
            req_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                locate_byte(i_data_byte, i_last_byte, i_message_length);
                req_count <= req_count + 1;
            end
            if (o_valid && !i_stall) begin
                if (pending_status.size() == 0) begin
                    $error("status returned with no request pending");
                    err_count++;
                end else begin
                    want = pending_status.pop_front();
                    if (o_status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, o_status);
                        err_count++;
                    end
                    if (o_metadata_length !== want.meta) begin
                        $error("metadata_length: expected %0d, got %0d",
                               want.meta, o_metadata_length);
                        err_count++;
                    end
                    if (o_payload_offset !== want.poff) begin
                        $error("payload_offset: expected %0d, got %0d",
                               want.poff, o_payload_offset);
                        err_count++;
                    end
                end
            end
            stuck <= ((i_valid && !o_stall) || (o_valid && !i_stall)) ? 0 : stuck + 1;
        end
    end

    initial begin
        int total;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_stall          = 1'b0;
        i_data_byte      = '0;
        i_last_byte      = 1'b0;
        i_message_length = '0;
        scan_clear();

        frag = '{8'h00};
        push_frag('1, 1'b0);
        frag = '{tag_byte(4'd15, WT_LENGTH), 8'h01, 8'hFF};
        push_frag('0, 1'b0);
        // candidate that ends before the last byte
        frag = '{tag_byte(4'd15, WT_LENGTH), 8'h00, 8'h00, 8'h00};
        push_frag(32'd5, 1'b0);
        frag = '{tag_byte(4'd1, WT_BAD6)};
        push_frag($urandom, 1'b0);
        frag = '{tag_byte(4'd1, WT_BAD7)};
        push_frag($urandom, 1'b0);
        frag = '{tag_byte(4'd1, WT_FIX64), 8'h11, 8'h22};
        push_frag($urandom, 1'b0);
        frag = '{tag_byte(4'd1, WT_FIX32), 8'h01, 8'h02, 8'h03, 8'h04,
                 tag_byte(4'd3, WT_SGROUP), tag_byte(4'd1, WT_EGROUP)};
        push_frag($urandom, 1'b0);
        frag.delete();
        repeat (10) put_byte(8'hFF);
        push_frag($urandom, 1'b0);

        total = fragment_reqs.size() + N_RANDOM;
        while (fragment_reqs.size() < total) add_fragment();
        total = fragment_reqs.size();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                while (req_count != total) @(posedge i_clk);
                while (pending_status.size() != 0) @(posedge i_clk);
                repeat (8) @(posedge i_clk);
            end
            begin
                while (stuck < STUCK_LIMIT) @(posedge i_clk);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
